// ----- design/ale_pkg.sv -----
// ale_pkg: types, codes and sizes shared by the list engine and its cells
// no dependencies
package ale_pkg;

    localparam int CAPACITY = 128;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        M_CLEAR  = 3'd0,
        M_INSERT = 3'd1,
        M_DELETE = 3'd2,
        M_LSRCH  = 3'd3,
        M_SORT   = 3'd4,
        M_BSRCH  = 3'd5,
        M_READ   = 3'd6,
        M_NONE   = 3'd7
    } t_mode;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         found_index;
        logic signed [31:0] read_data;
        logic [7:0]         count;
    } t_out;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INS,
        C_DEL,
        C_SWAP,
        C_LOAD,
        C_SHIFT
    } t_cop;

    typedef struct packed {
        t_cop               op;
        logic [IW-1:0]      pos;
        logic [CW-1:0]      cnt;
        logic signed [31:0] val;
        logic               phase;
    } t_cell_ctl;

endpackage

// ----- design/ale_cell.sv -----
// ale_cell: one list entry with its probe register
// depends on ale_pkg
module ale_cell
    import ale_pkg::*;
(
    input  logic               i_clk,
    input  logic [IW-1:0]      i_idx,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    input  logic signed [31:0] i_right_probe,
    output logic signed [31:0] o_data,
    output logic signed [31:0] o_probe
);

    logic signed [31:0] r_data;
    logic signed [31:0] r_probe;
    logic signed [31:0] n_data;
    logic signed [31:0] n_probe;
    logic [CW:0]        w_idx;
    logic [CW:0]        w_pos;
    logic [CW:0]        w_cnt;

    assign w_idx = (CW+1)'(i_idx);
    assign w_pos = (CW+1)'(i_ctl.pos);
    assign w_cnt = (CW+1)'(i_ctl.cnt);

    always_comb begin
        n_data  = r_data;
        n_probe = r_probe;
        case (i_ctl.op)
            C_INS: begin
                if (w_idx == w_pos) begin
                    n_data = i_ctl.val;
                end else if (w_idx > w_pos && w_idx <= w_cnt) begin
                    n_data = i_left;
                end
            end
            C_DEL: begin
                if (w_idx >= w_pos && w_idx + 1'b1 < w_cnt) begin
                    n_data = i_right;
                end
            end
            C_SWAP: begin
                // odd-even transposition: lower of a pair keeps min, upper keeps max
                if (i_idx[0] == i_ctl.phase && w_idx + 1'b1 < w_cnt) begin
                    if (i_right < r_data) begin
                        n_data = i_right;
                    end
                end else if (i_idx[0] != i_ctl.phase && w_idx != '0 && w_idx < w_cnt) begin
                    if (r_data < i_left) begin
                        n_data = i_left;
                    end
                end
            end
            C_LOAD:  n_probe = r_data;
            C_SHIFT: n_probe = i_right_probe;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_probe <= n_probe;
    end

    assign o_data  = r_data;
    assign o_probe = r_probe;

endmodule

// ----- design/array_list_engine.sv -----
// array_list_engine: top level, control sequencer and row of list cells
// depends on ale_pkg and ale_cell
//
// One item at a time, one result per item. Clear, bad requests and unused
// modes go straight to the result; insert and delete shift the cells above
// the position and update the count. Read and linear search load the probe
// chain and walk it, read up to position, linear search until the value or
// the count is reached. Sort runs count odd-even rounds over the cells.
// Binary search reloads the probe chain for each probe and walks to mid. A
// new item is taken once the result of the previous one has moved to the output register.
module array_list_engine
    import ale_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_LLOAD, S_LSCAN, S_RSCAN, S_SORT, S_BLOAD, S_BWALK, S_FIN
    } t_state;

    t_state             r_state;
    logic               r_ovalid;
    t_out               r_out;
    logic [CW-1:0]      r_cnt;
    t_mode              r_mode;
    logic signed [31:0] r_val;
    logic [IW-1:0]      r_pos;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_mid;
    logic [2:0]         r_st;
    logic [CW-1:0]      r_fnd;
    logic signed [31:0] r_rd;

    t_cell_ctl          w_ctl;
    logic signed [31:0] w_data  [CAPACITY];
    logic signed [31:0] w_probe [CAPACITY];
    logic [CW-1:0]      w_mid;
    logic [31:0]        w_ipos;
    logic [31:0]        w_icnt;
    logic [2:0]         w_dec_st;
    t_state             w_dec_state;
    logic               w_oload;

    assign w_mid   = r_lo + ((r_hi - r_lo - 1'b1) >> 1);
    assign w_ipos  = 32'(i_in_item.position);
    assign w_icnt  = 32'(r_cnt);
    assign w_oload = (r_state == S_FIN) && (!r_ovalid || i_out_ready);

    // decode of a new item: first status and next state
    always_comb begin
        w_dec_st    = ST_OK;
        w_dec_state = S_FIN;
        case (t_mode'(i_in_item.mode))
            M_INSERT: begin
                if (w_icnt == 32'(CAPACITY)) begin
                    w_dec_st = ST_FULL;
                end else if (w_ipos > w_icnt) begin
                    w_dec_st = ST_BADPOS;
                end else begin
                    w_dec_state = S_EXEC;
                end
            end
            M_DELETE, M_READ: begin
                if (r_cnt == '0) begin
                    w_dec_st = ST_EMPTY;
                end else if (w_ipos >= w_icnt) begin
                    w_dec_st = ST_BADPOS;
                end else if (t_mode'(i_in_item.mode) == M_DELETE) begin
                    w_dec_state = S_EXEC;
                end else begin
                    w_dec_state = S_LLOAD;
                end
            end
            M_LSRCH, M_SORT, M_BSRCH: begin
                if (r_cnt == '0) begin
                    w_dec_st = ST_EMPTY;
                end else if (t_mode'(i_in_item.mode) == M_LSRCH) begin
                    w_dec_state = S_LLOAD;
                end else if (t_mode'(i_in_item.mode) == M_SORT) begin
                    w_dec_state = S_SORT;
                end else begin
                    w_dec_state = S_BLOAD;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_ctl.op    = C_HOLD;
        w_ctl.pos   = r_pos;
        w_ctl.cnt   = r_cnt;
        w_ctl.val   = r_val;
        w_ctl.phase = r_k[0];
        case (r_state)
            S_EXEC:  w_ctl.op = (r_mode == M_INSERT) ? C_INS : C_DEL;
            S_LLOAD: w_ctl.op = C_LOAD;
            S_BLOAD: w_ctl.op = (r_lo < r_hi) ? C_LOAD : C_HOLD;
            S_LSCAN, S_RSCAN, S_BWALK: w_ctl.op = C_SHIFT;
            S_SORT:  w_ctl.op = C_SWAP;
            default: w_ctl.op = C_HOLD;
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ale_cell u_cell (
            .i_clk         (i_clk),
            .i_idx         (IW'(g)),
            .i_ctl         (w_ctl),
            .i_left        ((g == 0) ? 32'sd0 : w_data[(g == 0) ? 0 : g - 1]),
            .i_right       ((g == CAPACITY - 1) ? 32'sd0
                                : w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_right_probe ((g == CAPACITY - 1) ? 32'sd0
                                : w_probe[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data        (w_data[g]),
            .o_probe       (w_probe[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= t_mode'(i_in_item.mode);
                        r_val   <= i_in_item.value;
                        r_pos   <= IW'(i_in_item.position);
                        r_st    <= w_dec_st;
                        r_fnd   <= '0;
                        r_rd    <= '0;
                        r_k     <= '0;
                        r_lo    <= '0;
                        r_hi    <= r_cnt;
                        r_state <= w_dec_state;
                        if (t_mode'(i_in_item.mode) == M_CLEAR) begin
                            r_cnt <= '0;
                        end
                    end
                end
                S_EXEC: begin
                    r_cnt   <= (r_mode == M_INSERT) ? r_cnt + 1'b1 : r_cnt - 1'b1;
                    r_state <= S_FIN;
                end
                S_LLOAD: begin
                    r_state <= (r_mode == M_READ) ? S_RSCAN : S_LSCAN;
                end
                S_LSCAN: begin
                    if (w_probe[0] == r_val) begin
                        r_fnd   <= r_k;
                        r_state <= S_FIN;
                    end else if (r_k + 1'b1 == r_cnt) begin
                        r_st    <= ST_NOTFOUND;
                        r_state <= S_FIN;
                    end
                    r_k <= r_k + 1'b1;
                end
                S_RSCAN: begin
                    if (r_k == CW'(r_pos)) begin
                        r_rd    <= w_probe[0];
                        r_state <= S_FIN;
                    end
                    r_k <= r_k + 1'b1;
                end
                S_SORT: begin
                    if (r_k + 1'b1 >= r_cnt) begin
                        r_state <= S_FIN;
                    end
                    r_k <= r_k + 1'b1;
                end
                S_BLOAD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_k     <= '0;
                        r_state <= S_BWALK;
                    end else begin
                        r_st    <= ST_NOTFOUND;
                        r_state <= S_FIN;
                    end
                end
                S_BWALK: begin
                    if (r_k == r_mid) begin
                        if (w_probe[0] == r_val) begin
                            r_fnd   <= r_mid;
                            r_state <= S_FIN;
                        end else begin
                            if (w_probe[0] < r_val) begin
                                r_lo <= r_mid + 1'b1;
                            end else begin
                                r_hi <= r_mid;
                            end
                            r_state <= S_BLOAD;
                        end
                    end
                    r_k <= r_k + 1'b1;
                end
                S_FIN: begin
                    if (w_oload) begin
                        r_out.status      <= r_st;
                        r_out.found_index <= 7'(r_fnd);
                        r_out.read_data   <= r_rd;
                        r_out.count       <= 8'(r_cnt);
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

// ----- design/ale_check.sv -----
// ale_check: port-level checks on the list engine, bound to the top level
// depends on ale_pkg and array_list_engine
module ale_check
    import ale_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_item,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= ST_NOTFOUND)
        else $error("status code out of range");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_FULL |-> o_out_item.count == 8'(CAPACITY))
        else $error("full reported below capacity");

    a_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.found_index != '0 || o_out_item.read_data != '0)
            |-> o_out_item.status == ST_OK)
        else $error("index or data given with a failing status");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY |-> o_out_item.count == '0)
        else $error("empty reported with entries present");

endmodule

bind array_list_engine ale_check u_ale_check (.*);
